FILE: src/ksmp_pkg.sv
// Shared constants and types for the keyed substate mix generator.
`default_nettype none
package ksmp_pkg;
  localparam logic [63:0] SM_MUL1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] SM_MUL2 = 64'h94d049bb133111eb;
  localparam logic [63:0] RND_MUL = 64'h589965cc75374cc3;
  localparam logic [63:0] RND_ADD = 64'h33a213ec50ffe2e9;
  localparam logic [63:0] SEL_MUL = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] SEQ_MUL = 64'he7037ed1a0b428db;
  localparam logic [63:0] SEQ_ADD = 64'h8f3907f7b2b80c35;

  localparam int RAW_W = 32;
  localparam int RNG_W = 16;

  typedef enum logic [2:0] {
    REG_A       = 3'd0,
    REG_B       = 3'd1,
    REG_C       = 3'd2,
    REG_D       = 3'd3,
    REG_E       = 3'd4,
    REG_DEFAULT = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [RNG_W-1:0] lo;
    logic [RNG_W-1:0] hi;
  } side_t;

  function automatic reg_idx_t pick_reg(input logic [31:0] sel);
    reg_idx_t r;
    r = REG_DEFAULT;
    if (sel == 32'd0 || sel == 32'd1 || sel == 32'd14 || sel == 32'd15 ||
        sel == 32'd33 || sel == 32'd34) r = REG_A;
    else if (sel == 32'd2) r = REG_B;
    else if (sel == 32'd3 || (sel >= 32'd16 && sel <= 32'd20)) r = REG_C;
    else if ((sel >= 32'd21 && sel <= 32'd26) || sel == 32'd38 || sel == 32'd39) r = REG_D;
    else if ((sel >= 32'd28 && sel <= 32'd32) || (sel >= 32'd35 && sel <= 32'd37)) r = REG_E;
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: src/ksmp_mix.sv
// Two-stage keyed mix: scale request words, combine with key, first xor-shift.
`default_nettype none
module ksmp_mix (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           valid_in,
  input  wire logic [31:0]    sel,
  input  wire logic [31:0]    seq,
  input  wire logic [31:0]    rnd,
  input  wire logic [63:0]    key,
  input  wire ksmp_pkg::side_t side_in,
  output logic                valid_out,
  output logic [63:0]         z,
  output ksmp_pkg::side_t     side_out
);
  logic            v1;
  logic [63:0]     key1;
  ksmp_pkg::side_t side1;
  logic [63:0]     r_lo, s_lo, q_lo;
  logic [31:0]     r_hi, s_hi, q_hi;
  logic [63:0]     tr, ts, tq, mix;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      valid_out <= 1'b0;
    end else begin
      v1 <= valid_in;
      valid_out <= v1;
    end
  end

  always_ff @(posedge clk) begin
    r_lo <= rnd * ksmp_pkg::RND_MUL[31:0];
    r_hi <= 32'(rnd * ksmp_pkg::RND_MUL[63:32]);
    s_lo <= sel * ksmp_pkg::SEL_MUL[31:0];
    s_hi <= 32'(sel * ksmp_pkg::SEL_MUL[63:32]);
    q_lo <= seq * ksmp_pkg::SEQ_MUL[31:0];
    q_hi <= 32'(seq * ksmp_pkg::SEQ_MUL[63:32]);
    key1 <= key;
    side1 <= side_in;
  end

  always_comb begin
    tr  = r_lo + {r_hi, 32'd0} + ksmp_pkg::RND_ADD;
    ts  = s_lo + {s_hi, 32'd0};
    tq  = q_lo + {q_hi, 32'd0} + ksmp_pkg::SEQ_ADD;
    mix = key1 ^ tr ^ ts ^ tq;
  end

  always_ff @(posedge clk) begin
    z <= mix ^ (mix >> 30);
    side_out <= side1;
  end
endmodule
`default_nettype wire

FILE: src/ksmp_mul.sv
// Two-stage 64x64 low-half multiply by a constant from 32x32 partial products.
`default_nettype none
module ksmp_mul (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            valid_in,
  input  wire logic [63:0]     a,
  input  wire logic [63:0]     c,
  input  wire ksmp_pkg::side_t side_in,
  output logic                 valid_out,
  output logic [63:0]          prod,
  output ksmp_pkg::side_t      side_out
);
  logic            v1;
  logic [63:0]     p0;
  logic [31:0]     p1, p2;
  ksmp_pkg::side_t side1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      valid_out <= 1'b0;
    end else begin
      v1 <= valid_in;
      valid_out <= v1;
    end
  end

  always_ff @(posedge clk) begin
    p0 <= a[31:0] * c[31:0];
    p1 <= 32'(a[31:0] * c[63:32]);
    p2 <= 32'(a[63:32] * c[31:0]);
    side1 <= side_in;
    prod <= p0 + {p1 + p2, 32'd0};
    side_out <= side1;
  end
endmodule
`default_nettype wire

FILE: src/ksmp_mod.sv
// Pipelined range mapping: one remainder bit per stage, then offset by low bound.
`default_nettype none
module ksmp_mod (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        valid_in,
  input  wire logic [ksmp_pkg::RAW_W-1:0]  raw_in,
  input  wire ksmp_pkg::side_t             side_in,
  output logic                             valid_out,
  output logic [ksmp_pkg::RAW_W-1:0]       raw_out,
  output logic [ksmp_pkg::RNG_W-1:0]       mapped_out
);
  localparam int N = ksmp_pkg::RAW_W;
  localparam int W = ksmp_pkg::RNG_W;

  logic         v   [0:N];
  logic [N-1:0] raw [0:N];
  logic [W-1:0] lo  [0:N];
  logic [W:0]   d   [0:N];
  logic         emp [0:N];
  logic [W-1:0] rem [0:N];

  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else v[0] <= valid_in;
  end

  always_ff @(posedge clk) begin
    raw[0] <= raw_in;
    lo[0]  <= side_in.lo;
    d[0]   <= {1'b0, side_in.hi} - {1'b0, side_in.lo} + 17'd1;
    emp[0] <= side_in.hi <= side_in.lo;
    rem[0] <= '0;
  end

  for (genvar i = 0; i < N; i++) begin : g_div
    logic [W:0] t;
    assign t = {rem[i], raw[i][N-1-i]};
    always_ff @(posedge clk) begin
      if (rst) v[i+1] <= 1'b0;
      else v[i+1] <= v[i];
    end
    always_ff @(posedge clk) begin
      raw[i+1] <= raw[i];
      lo[i+1]  <= lo[i];
      d[i+1]   <= d[i];
      emp[i+1] <= emp[i];
      rem[i+1] <= (t >= d[i]) ? W'(t - d[i]) : W'(t);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) valid_out <= 1'b0;
    else valid_out <= v[N];
  end

  always_ff @(posedge clk) begin
    raw_out <= raw[N];
    mapped_out <= emp[N] ? lo[N] : lo[N] + rem[N];
  end

  a_rem_below_size: assert property (@(posedge clk) disable iff (rst)
    (v[N] && !emp[N]) |-> ({1'b0, rem[N]} < d[N]))
    else $error("remainder not below range size");
  a_empty_low: assert property (@(posedge clk) disable iff (rst)
    (v[N] && emp[N]) |=> (mapped_out == $past(lo[N])))
    else $error("empty range not mapped to low bound");
  a_mapped_above_low: assert property (@(posedge clk) disable iff (rst)
    v[N] |=> (mapped_out >= $past(lo[N])))
    else $error("mapped value below low bound");
endmodule
`default_nettype wire

FILE: src/keyed_substate_mix_prng.sv
// Top level of the keyed substate mix random generator.
`default_nettype none
// Takes one request per cycle; busy is always low. Each request yields one
// result, marked by done, after the keyed mix, the two 64-bit finalizer
// multiplies, the fold and the remainder pipeline (input register, 32 bit
// stages, output register). Results cannot be held off. Sub-state registers
// sit at byte address 8*i (64-bit data); write them only while no request is
// in flight.
module keyed_substate_mix_prng (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] selector,
  input  wire logic [31:0] sequence_req,
  input  wire logic [31:0] round_number,
  input  wire logic [15:0] range_low,
  input  wire logic [15:0] range_high,
  output logic             done,
  output logic [31:0]      raw_value,
  output logic [15:0]      mapped_value
);
  logic [63:0] substate_a, substate_b, substate_c, substate_d, substate_e;
  logic [63:0] substate_default;
  logic [63:0] key;
  ksmp_pkg::reg_idx_t widx;
  ksmp_pkg::side_t side0, side_m, side_1, side_2, side_f;
  logic v_m, v_1, v_2, v_f;
  logic [63:0] z_m, p1, p2, h;
  logic [31:0] raw_f;

  assign pready = 1'b1;
  assign busy = 1'b0;
  assign widx = ksmp_pkg::reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      substate_a <= '0;
      substate_b <= '0;
      substate_c <= '0;
      substate_d <= '0;
      substate_e <= '0;
      substate_default <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        ksmp_pkg::REG_A:       substate_a <= pwdata;
        ksmp_pkg::REG_B:       substate_b <= pwdata;
        ksmp_pkg::REG_C:       substate_c <= pwdata;
        ksmp_pkg::REG_D:       substate_d <= pwdata;
        ksmp_pkg::REG_E:       substate_e <= pwdata;
        ksmp_pkg::REG_DEFAULT: substate_default <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      ksmp_pkg::REG_A:       prdata = substate_a;
      ksmp_pkg::REG_B:       prdata = substate_b;
      ksmp_pkg::REG_C:       prdata = substate_c;
      ksmp_pkg::REG_D:       prdata = substate_d;
      ksmp_pkg::REG_E:       prdata = substate_e;
      ksmp_pkg::REG_DEFAULT: prdata = substate_default;
      default:               prdata = '0;
    endcase
  end

  always_comb begin
    unique case (ksmp_pkg::pick_reg(selector))
      ksmp_pkg::REG_A: key = substate_a;
      ksmp_pkg::REG_B: key = substate_b;
      ksmp_pkg::REG_C: key = substate_c;
      ksmp_pkg::REG_D: key = substate_d;
      ksmp_pkg::REG_E: key = substate_e;
      default:         key = substate_default;
    endcase
    side0.lo = range_low;
    side0.hi = range_high;
  end

  ksmp_mix u_mix (
    .clk(clk), .rst(rst), .valid_in(start), .sel(selector), .seq(sequence_req),
    .rnd(round_number), .key(key), .side_in(side0),
    .valid_out(v_m), .z(z_m), .side_out(side_m)
  );

  ksmp_mul u_mul1 (
    .clk(clk), .rst(rst), .valid_in(v_m), .a(z_m), .c(ksmp_pkg::SM_MUL1),
    .side_in(side_m), .valid_out(v_1), .prod(p1), .side_out(side_1)
  );

  ksmp_mul u_mul2 (
    .clk(clk), .rst(rst), .valid_in(v_1), .a(p1 ^ (p1 >> 27)), .c(ksmp_pkg::SM_MUL2),
    .side_in(side_1), .valid_out(v_2), .prod(p2), .side_out(side_2)
  );

  assign h = p2 ^ (p2 >> 31);

  always_ff @(posedge clk) begin
    if (rst) v_f <= 1'b0;
    else v_f <= v_2;
  end

  always_ff @(posedge clk) begin
    raw_f <= h[31:0] ^ h[63:32];
    side_f <= side_2;
  end

  ksmp_mod u_mod (
    .clk(clk), .rst(rst), .valid_in(v_f), .raw_in(raw_f), .side_in(side_f),
    .valid_out(done), .raw_out(raw_value), .mapped_out(mapped_value)
  );
endmodule
`default_nettype wire
